FILE: rtl/ddmr_pkg.sv
// Shared types, codes and constants for the differential drive mixer with speed ramp.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package ddmr_pkg;

  localparam int CMD_W      = 3;
  localparam int DIR_W      = 2;
  localparam int TURN_W     = 8;
  localparam int SPEED_W    = 8;
  localparam int DRIVE_W    = 8;
  localparam int MAG_W      = 7;
  localparam int RATIO_W    = 9;
  localparam int PROD_W     = MAG_W + RATIO_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [MAG_W-1:0]   MAX_SPEED_RST    = 7'd127;
  localparam logic [MAG_W-1:0]   NORMAL_SPEED_RST = 7'd80;
  localparam logic [RATIO_W-1:0] TURN_RATIO_RST   = 9'd64;
  localparam logic [MAG_W-1:0]   ACCEL_STEP_RST   = 7'd4;
  localparam logic [RATIO_W-1:0] RATIO_ONE        = 9'd256;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK       = 3'd0,
    CMD_SET_DIR    = 3'd1,
    CMD_SET_TURN   = 3'd2,
    CMD_SET_BOOST  = 3'd3,
    CMD_SET_SPEED  = 3'd4,
    CMD_SET_TARGET = 3'd5
  } ddmr_cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_SPEED    = 2'd0,
    CFG_NORMAL_SPEED = 2'd1,
    CFG_TURN_RATIO   = 2'd2,
    CFG_ACCEL_STEP   = 2'd3
  } ddmr_cfg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RATIO,
    ST_SPIN,
    ST_MIX
  } ddmr_state_e;

  typedef struct packed {
    logic [CMD_W-1:0]          command;
    logic signed [DIR_W-1:0]   dir_value;
    logic signed [TURN_W-1:0]  turn_value;
    logic                      boost_value;
    logic signed [SPEED_W-1:0] speed_value;
  } ddmr_item_t;

  typedef struct packed {
    logic accept;
    logic ratio_en;
    logic spin_en;
    logic mix_en;
  } ddmr_ctrl_t;

  typedef struct packed {
    logic tick_req;
  } ddmr_stat_t;

endpackage

`default_nettype wire

FILE: rtl/ddmr_in_if.sv
// Command channel: valid/ready handshake plus one command transaction.
// Depends on ddmr_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ddmr_in_if import ddmr_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          command;
  logic signed [DIR_W-1:0]   dir_value;
  logic signed [TURN_W-1:0]  turn_value;
  logic                      boost_value;
  logic signed [SPEED_W-1:0] speed_value;

  modport source (output valid, command, dir_value, turn_value, boost_value, speed_value,
                  input ready);
  modport sink (input valid, command, dir_value, turn_value, boost_value, speed_value,
                output ready);
endinterface

`default_nettype wire

FILE: rtl/ddmr_out_if.sv
// Drive channel: valid/ready handshake plus signed left and right wheel speeds.
// Depends on ddmr_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ddmr_out_if import ddmr_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] left_drive;
  logic signed [DRIVE_W-1:0] right_drive;

  modport source (output valid, left_drive, right_drive, input ready);
  modport sink (input valid, left_drive, right_drive, output ready);
endinterface

`default_nettype wire

FILE: rtl/ddmr_ctrl.sv
// Sequencer for the drive mixer: accepts transactions, steps a tick through
// ratio, spin and mix, and owns the output valid. Depends on ddmr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ddmr_ctrl import ddmr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  ddmr_stat_t stat_i,
  output ddmr_ctrl_t ctrl_o
);

  ddmr_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d         = state_q;
    ctrl_o          = '0;
    in_ready_o      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        ctrl_o.accept = in_valid_i;
        if (in_valid_i && stat_i.tick_req) begin
          state_d = ST_RATIO;
        end
      end
      ST_RATIO: begin
        ctrl_o.ratio_en = 1'b1;
        state_d         = ST_SPIN;
      end
      ST_SPIN: begin
        ctrl_o.spin_en = 1'b1;
        state_d        = ST_MIX;
      end
      ST_MIX: begin
        if (out_free) begin
          ctrl_o.mix_en = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (ctrl_o.mix_en) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  a_tick_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.accept && stat_i.tick_req |=> state_q == ST_RATIO)
    else $error("tick did not start the sequence");

  a_mix_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MIX && out_free |=> out_valid_q && state_q == ST_IDLE)
    else $error("mix did not load the output");

  a_valid_from_mix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_MIX))
    else $error("output valid without a mix step");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> !ctrl_o.accept)
    else $error("transaction accepted mid-sequence");

endmodule

`default_nettype wire

FILE: rtl/ddmr_datapath.sv
// Datapath for the drive mixer: settings, motion state, shared 7x9 multiplier,
// divide-by-127 correction and the output registers. Depends on ddmr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ddmr_datapath import ddmr_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i,
  input  ddmr_item_t                item_i,
  input  ddmr_ctrl_t                ctrl_i,
  output ddmr_stat_t                stat_o,
  output logic signed [DRIVE_W-1:0] left_o,
  output logic signed [DRIVE_W-1:0] right_o
);

  function automatic logic [RATIO_W-1:0] div127(input logic [PROD_W-2:0] x);
    logic [PROD_W+5:0] t;
    logic [7:0]        q;
    logic [PROD_W-1:0] qm;
    logic [PROD_W-1:0] r;
    t  = {7'd0, x} + {x, 7'd0};
    q  = t[PROD_W+5:PROD_W-2];
    qm = {1'b0, q, 7'd0} - {8'd0, q};
    r  = {1'b0, x} - qm;
    div127 = (r >= 16'd127) ? ({1'b0, q} + 9'd1) : {1'b0, q};
  endfunction

  function automatic logic signed [7:0] clamp8(input logic signed [7:0] v);
    clamp8 = (v == 8'sh80) ? 8'sh81 : v;
  endfunction

  function automatic logic [7:0] abs8(input logic signed [7:0] v);
    abs8 = v[7] ? 8'(-v) : 8'(v);
  endfunction

  logic [MAG_W-1:0]          max_q, normal_q, step_q;
  logic [RATIO_W-1:0]        tratio_q;

  logic signed [SPEED_W-1:0] tgt_q, tgt_d, cur_q, cur_d;
  logic signed [TURN_W-1:0]  turn_q, turn_d;
  logic signed [DIR_W-1:0]   dir_q, dir_d;
  logic                      boost_q, boost_d;

  logic [PROD_W-1:0]         prod_q;
  logic [RATIO_W-1:0]        ratio_q;
  logic [MAG_W-1:0]          spin_q;
  logic signed [DRIVE_W-1:0] left_q, right_q, left_d, right_d;

  logic signed [DIR_W-1:0]   dir_c;
  logic signed [7:0]         mag_s, dir_tgt;
  logic                      opposite;
  logic signed [8:0]         step_s, sum_s;
  logic signed [7:0]         ramp_s, cur_tick;
  logic [MAG_W-1:0]          turn_abs, cur_abs, spin_mag;
  logic [RATIO_W-1:0]        rq_eff, ratio_inv;
  logic [MAG_W-1:0]          mul_a;
  logic [RATIO_W-1:0]        mul_b;
  logic [PROD_W-1:0]         prod_d;
  logic signed [7:0]         inner_s, spin_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q    <= MAX_SPEED_RST;
      normal_q <= NORMAL_SPEED_RST;
      tratio_q <= TURN_RATIO_RST;
      step_q   <= ACCEL_STEP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAX_SPEED:    max_q    <= cfg_data_i[MAG_W-1:0];
        CFG_NORMAL_SPEED: normal_q <= cfg_data_i[MAG_W-1:0];
        CFG_TURN_RATIO:   tratio_q <= cfg_data_i[RATIO_W-1:0];
        CFG_ACCEL_STEP:   step_q   <= cfg_data_i[MAG_W-1:0];
        default: ;
      endcase
    end
  end

  assign stat_o.tick_req = (item_i.command == CMD_TICK);

  // direction decode and target
  assign dir_c = (item_i.dir_value == 2'sb10) ? 2'sb11 : item_i.dir_value;
  assign mag_s = $signed({1'b0, (boost_q ? max_q : normal_q)});
  always_comb begin
    case (dir_c)
      2'sb01:  dir_tgt = mag_s;
      2'sb11:  dir_tgt = -mag_s;
      default: dir_tgt = 8'sd0;
    endcase
  end
  assign opposite = (dir_c == 2'sb01 && dir_q == 2'sb11) ||
                    (dir_c == 2'sb11 && dir_q == 2'sb01);

  // ramp toward target, saturating
  always_comb begin
    case (dir_q)
      2'sb01:  step_s = $signed({2'b00, step_q});
      2'sb11:  step_s = -$signed({2'b00, step_q});
      default: step_s = 9'sd0;
    endcase
  end
  assign sum_s  = $signed({cur_q[7], cur_q}) + step_s;
  assign ramp_s = (sum_s > 9'sd127) ? 8'sd127 :
                  (sum_s < -9'sd127) ? -8'sd127 : sum_s[7:0];
  assign cur_tick = (abs8(cur_q) < abs8(tgt_q)) ? ramp_s : tgt_q;

  always_comb begin
    tgt_d   = tgt_q;
    cur_d   = cur_q;
    turn_d  = turn_q;
    dir_d   = dir_q;
    boost_d = boost_q;
    if (ctrl_i.accept) begin
      case (item_i.command)
        CMD_TICK: cur_d = cur_tick;
        CMD_SET_DIR: begin
          tgt_d = dir_tgt;
          dir_d = dir_c;
          if (dir_c == 2'sb00) begin
            cur_d = 8'sd0;
          end else if (boost_q || opposite) begin
            cur_d = dir_tgt;
          end
        end
        CMD_SET_TURN:   turn_d  = clamp8(item_i.turn_value);
        CMD_SET_BOOST:  boost_d = item_i.boost_value;
        CMD_SET_SPEED:  cur_d   = clamp8(item_i.speed_value);
        CMD_SET_TARGET: tgt_d   = clamp8(item_i.speed_value);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_q   <= '0;
      cur_q   <= '0;
      turn_q  <= '0;
      dir_q   <= '0;
      boost_q <= 1'b0;
    end else begin
      tgt_q   <= tgt_d;
      cur_q   <= cur_d;
      turn_q  <= turn_d;
      dir_q   <= dir_d;
      boost_q <= boost_d;
    end
  end

  // shared multiplier: turn*(1-ratio), turn*normal, |speed|*ratio
  assign turn_abs  = MAG_W'(abs8(turn_q));
  assign cur_abs   = MAG_W'(abs8(cur_q));
  assign rq_eff    = (tratio_q > RATIO_ONE) ? RATIO_ONE : tratio_q;
  assign ratio_inv = RATIO_ONE - rq_eff;

  always_comb begin
    mul_a = turn_abs;
    mul_b = ratio_inv;
    if (ctrl_i.ratio_en) begin
      mul_b = {2'b00, normal_q};
    end else if (ctrl_i.spin_en) begin
      mul_a = cur_abs;
      mul_b = ratio_q;
    end
  end
  assign prod_d = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept || ctrl_i.ratio_en || ctrl_i.spin_en) begin
      prod_q <= prod_d;
    end
    if (ctrl_i.ratio_en) begin
      ratio_q <= RATIO_ONE - div127(prod_q[PROD_W-2:0]);
    end
    if (ctrl_i.spin_en) begin
      spin_q <= MAG_W'(div127(prod_q[PROD_W-2:0]));
    end
    if (ctrl_i.mix_en) begin
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

  // mix
  assign inner_s  = cur_q[7] ? -$signed({1'b0, prod_q[PROD_W-2:8]})
                             : $signed({1'b0, prod_q[PROD_W-2:8]});
  assign spin_mag = boost_q ? max_q : spin_q;
  assign spin_s   = $signed({1'b0, spin_mag});

  always_comb begin
    if (cur_q == 8'sd0) begin
      if (turn_q > 8'sd0) begin
        left_d  = spin_s;
        right_d = -spin_s;
      end else if (turn_q < 8'sd0) begin
        left_d  = -spin_s;
        right_d = spin_s;
      end else begin
        left_d  = 8'sd0;
        right_d = 8'sd0;
      end
    end else if (turn_q[7]) begin
      left_d  = inner_s;
      right_d = cur_q;
    end else begin
      left_d  = cur_q;
      right_d = inner_s;
    end
  end

  assign left_o  = left_q;
  assign right_o = right_q;

  a_cur_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q != 8'sh80 && tgt_q != 8'sh80)
    else $error("speed left the symmetric range");

  a_turn_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    turn_q != 8'sh80)
    else $error("turn rate left the symmetric range");

  a_dir_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dir_q != 2'sb10)
    else $error("direction holds an illegal code");

endmodule

`default_nettype wire

FILE: rtl/differential_drive_mixer_ramp_top.sv
// Top level of the differential drive mixer with speed ramp: joins the
// sequencer and the datapath. Depends on ddmr_pkg, ddmr_in_if and ddmr_out_if.
//
//   channel   direction  handshake       payload
//   in_if     sink       valid / ready   command, dir_value, turn_value, boost_value,
//                                        speed_value
//   out_if    source     valid / ready   left_drive, right_drive
//   cfg       input      cfg_we_i        cfg_idx_i, cfg_data_i
//
// A non-tick transaction is taken in the accept step alone; a tick steps through accept
// with ramp, ratio divide, spin divide and mix, paced by the single shared 7x9 multiplier.
// Reset restores the settings to their defaults and clears speed, target, turn,
// direction and boost. A stalled output holds the mix step; other commands are
// still taken while a result waits.
`timescale 1ns / 1ps
`default_nettype none

module differential_drive_mixer_ramp_top import ddmr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  ddmr_in_if.sink               in_if,
  ddmr_out_if.source            out_if
);

  ddmr_item_t item;
  ddmr_ctrl_t ctrl;
  ddmr_stat_t stat;

  assign item.command     = in_if.command;
  assign item.dir_value   = in_if.dir_value;
  assign item.turn_value  = in_if.turn_value;
  assign item.boost_value = in_if.boost_value;
  assign item.speed_value = in_if.speed_value;

  ddmr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  ddmr_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (item),
    .ctrl_i     (ctrl),
    .stat_o     (stat),
    .left_o     (out_if.left_drive),
    .right_o    (out_if.right_drive)
  );

endmodule

`default_nettype wire
